/* design/tmhq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types, constants and helpers for the ternary max-heap queue.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int CAPACITY = 512;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 10;
  localparam int PTR_W    = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 32;
  localparam int ENTRY_W  = KEY_W + ID_W;

  // reciprocal of three, exact floor for every IDX_W-bit operand
  localparam logic [IDX_W:0] DIV3_MUL = (IDX_W + 1)'((2 ** (IDX_W + 1) + 2) / 3);

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DEL_MAX  = 3'd1,
    CMD_DEL_MIN  = 3'd2,
    CMD_PEEK_MAX = 3'd3,
    CMD_PEEK_MIN = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUP_SCAN,
    ST_INS_CHK,
    ST_UP_RD,
    ST_UP_CK,
    ST_MIN_SCAN,
    ST_RD_ROOT,
    ST_GET_ROOT,
    ST_RD_LAST,
    ST_GET_LAST,
    ST_DN_SET,
    ST_DN_SCAN,
    ST_DN_CK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [KEY_W-1:0] item_key;
    logic [ID_W-1:0]         item_id;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [ID_W-1:0]         out_id;
    logic [CNT_W-1:0]        entry_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  function automatic logic [IDX_W-1:0] div3(input logic [IDX_W-1:0] x);
    logic [2*IDX_W:0] p;
    p = {{(IDX_W + 1){1'b0}}, x} * {{IDX_W{1'b0}}, DIV3_MUL};
    return p[2*IDX_W:IDX_W+1];
  endfunction

  function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

/* design/tmhq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/ternary_max_heap_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_max_heap_queue_core
// 3-ary max-heap priority queue over one RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
// insert scans all n entries for a duplicate identifier, one RAM read a cycle, then
//   sifts up one level at a time; delete max sifts down from the root
// delete/peek min scan the leaves for the smallest key, then delete min sifts up
// one request at a time: busy is high from acceptance to the result strobe
// result is held one cycle with rsp_valid_o; the receiver cannot stall
// reset empties the queue; RAM contents are left as they are
module ternary_max_heap_queue_core
  import tmhq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  state_e           state_q, state_d;
  logic [2:0]       cmd_q, cmd_d;
  entry_t           item_q, item_d;
  entry_t           best_q, best_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic [ID_W-1:0]  oid_q, oid_d;
  logic [1:0]       status_q, status_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [PTR_W-1:0] lim_q, lim_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic             hit_q, hit_d;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t           rdata;

  logic [PTR_W-1:0] count_ext, first, first3;
  logic             scan_end;

  assign rdata     = entry_t'(rdata_raw);
  assign count_ext = PTR_W'(count_q);
  assign first     = PTR_W'({cur_q, 1'b0}) + PTR_W'(cur_q) + PTR_W'(1);
  assign first3    = first + PTR_W'(3);
  assign scan_end  = (ptr_q >= lim_q) && !pend_q;

  tmhq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    item_q     <= item_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    okey_q     <= okey_d;
    oid_q      <= oid_d;
    status_q   <= status_d;
    cur_q      <= cur_d;
    ptr_q      <= ptr_d;
    lim_q      <= lim_d;
    pidx_q     <= pidx_d;
    hit_q      <= hit_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    item_d     = item_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    okey_d     = okey_q;
    oid_d      = oid_q;
    status_d   = status_q;
    count_d    = count_q;
    cur_d      = cur_q;
    ptr_d      = ptr_q;
    lim_d      = lim_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    hit_d      = hit_q;
    we         = 1'b0;
    waddr      = cur_q;
    wdata      = item_q;
    raddr      = '0;

    // shared scan pipeline: issue one read a cycle, judge the previous one
    if (state_q == ST_DUP_SCAN || state_q == ST_MIN_SCAN || state_q == ST_DN_SCAN) begin
      if (ptr_q < lim_q) begin
        raddr  = ptr_q[IDX_W-1:0];
        pend_d = 1'b1;
        pidx_d = ptr_q[IDX_W-1:0];
        ptr_d  = ptr_q + PTR_W'(1);
      end
      if (pend_q) begin
        unique case (state_q)
          ST_DUP_SCAN: begin
            if (rdata.id == item_q.id) hit_d = 1'b1;
          end
          ST_MIN_SCAN: begin
            if (!hit_q || key_gt(best_q.key, rdata.key)) begin
              best_d     = rdata;
              best_idx_d = pidx_q;
              hit_d      = 1'b1;
            end
          end
          default: begin
            if (!hit_q || key_gt(rdata.key, best_q.key)) begin
              best_d     = rdata;
              best_idx_d = pidx_q;
              hit_d      = 1'b1;
            end
          end
        endcase
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d       = req_i.command;
          item_d.key  = req_i.item_key;
          item_d.id   = req_i.item_id;
          okey_d      = '0;
          oid_d       = '0;
          status_d    = STAT_OK;
          hit_d       = 1'b0;
          unique case (req_i.command)
            CMD_INSERT: begin
              ptr_d   = '0;
              lim_d   = count_ext;
              state_d = ST_DUP_SCAN;
            end
            CMD_DEL_MAX, CMD_PEEK_MAX: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_RD_ROOT;
              end
            end
            CMD_DEL_MIN, CMD_PEEK_MIN: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = ST_DONE;
              end else begin
                // leaves start after the parent of the last entry
                if (count_q == CNT_W'(1)) begin
                  ptr_d = '0;
                end else begin
                  ptr_d = PTR_W'(div3(IDX_W'(count_q - CNT_W'(2)))) + PTR_W'(1);
                end
                lim_d   = count_ext;
                state_d = ST_MIN_SCAN;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DUP_SCAN: begin
        if (scan_end) state_d = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        if (hit_q) begin
          status_d = STAT_DUP;
          state_d  = ST_DONE;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          status_d = STAT_FULL;
          state_d  = ST_DONE;
        end else begin
          cur_d   = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
          state_d = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        if (cur_q == '0) begin
          we      = 1'b1;
          state_d = ST_DONE;
        end else begin
          pidx_d  = div3(cur_q - IDX_W'(1));
          raddr   = pidx_d;
          state_d = ST_UP_CK;
        end
      end
      ST_UP_CK: begin
        we = 1'b1;
        if (key_gt(item_q.key, rdata.key)) begin
          wdata   = rdata;
          cur_d   = pidx_q;
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MIN_SCAN: begin
        if (scan_end) begin
          okey_d = best_q.key;
          oid_d  = best_q.id;
          if (cmd_q == CMD_PEEK_MIN) state_d = ST_DONE;
          else                       state_d = ST_RD_LAST;
        end
      end
      ST_RD_ROOT: begin
        raddr   = '0;
        state_d = ST_GET_ROOT;
      end
      ST_GET_ROOT: begin
        okey_d = rdata.key;
        oid_d  = rdata.id;
        if (cmd_q == CMD_PEEK_MAX) state_d = ST_DONE;
        else                       state_d = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        raddr   = IDX_W'(count_q - CNT_W'(1));
        state_d = ST_GET_LAST;
      end
      ST_GET_LAST: begin
        item_d  = rdata;
        count_d = count_q - CNT_W'(1);
        if (cmd_q == CMD_DEL_MAX) begin
          if (count_q == CNT_W'(1)) begin
            state_d = ST_DONE;
          end else begin
            cur_d   = '0;
            state_d = ST_DN_SET;
          end
        end else begin
          if (best_idx_q == IDX_W'(count_q - CNT_W'(1))) begin
            state_d = ST_DONE;
          end else begin
            cur_d   = best_idx_q;
            state_d = ST_UP_RD;
          end
        end
      end
      ST_DN_SET: begin
        if (first >= count_ext) begin
          we      = 1'b1;
          state_d = ST_DONE;
        end else begin
          ptr_d   = first;
          lim_d   = (first3 > count_ext) ? count_ext : first3;
          hit_d   = 1'b0;
          state_d = ST_DN_SCAN;
        end
      end
      ST_DN_SCAN: begin
        if (scan_end) state_d = ST_DN_CK;
      end
      ST_DN_CK: begin
        we = 1'b1;
        if (key_gt(best_q.key, item_q.key)) begin
          wdata   = best_q;
          cur_d   = best_idx_q;
          state_d = ST_DN_SET;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy                = (state_q != ST_IDLE);
  assign rsp_valid_o         = (state_q == ST_DONE);
  assign rsp_o.status        = status_q;
  assign rsp_o.out_key       = okey_q;
  assign rsp_o.out_id        = oid_q;
  assign rsp_o.entry_count   = count_q;

`ifndef SYNTHESIS
  a_strobe_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !busy && !rsp_valid_o)
    else $error("result strobe not followed by idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == STAT_EMPTY |-> rsp_o.out_key == '0 && rsp_o.out_id == '0)
    else $error("empty result carries an entry");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ternary max-heap queue. Directed table first,
// then random command mixes, one of which fills the store to capacity; each result
// is checked against a behavioural heap in the bench or a typed row's own value.
// ----------------------------------------------------------------------------
module tb_top;
  import tmhq_pkg::*;

  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int         CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] id;
    bit          typed;
    rsp_t        rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  logic signed [KEY_W-1:0] heap_key [CAPACITY];
  logic [ID_W-1:0]         heap_id  [CAPACITY];
  int                      heap_n = 0;

  rsp_t      pending_rsps [$];
  stim_row_t stim_table [$];
  int        n_errors = 0;
  int        n_cycles = 0;
  int        idle_pct = 0;

  ternary_max_heap_queue_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void heap_swap(int a, int b);
    logic signed [KEY_W-1:0] k;
    logic [ID_W-1:0]         d;
    k = heap_key[a]; heap_key[a] = heap_key[b]; heap_key[b] = k;
    d = heap_id[a];  heap_id[a]  = heap_id[b];  heap_id[b]  = d;
  endfunction

  function automatic void heap_sift_up(int i);
    int p;
    while (i > 0 && i < heap_n) begin
      p = (i - 1) / 3;
      if (!(heap_key[i] > heap_key[p])) break;
      heap_swap(i, p);
      i = p;
    end
  endfunction

  function automatic void heap_sift_down(int i);
    int first;
    int best;
    while (i < heap_n) begin
      first = 3 * i + 1;
      if (first >= heap_n) break;
      best = first;
      for (int c = first + 1; c < first + 3 && c < heap_n; c++)
        if (heap_key[c] > heap_key[best]) best = c;
      if (!(heap_key[best] > heap_key[i])) break;
      heap_swap(i, best);
      i = best;
    end
  endfunction

  // first smallest key among the leaves; root alone counts as a leaf
  function automatic int heap_min_leaf();
    int lo;
    int best;
    lo = (heap_n <= 1) ? 0 : (heap_n - 2) / 3 + 1;
    best = lo;
    for (int i = lo + 1; i < heap_n; i++)
      if (heap_key[best] > heap_key[i]) best = i;
    return best;
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    bit   dup;
    int   pos;
    int   last;
    o = '0;
    o.status = STAT_OK;
    if (r.command == CMD_INSERT) begin
      dup = 1'b0;
      for (int i = 0; i < heap_n; i++)
        if (heap_id[i] == r.item_id) dup = 1'b1;
      if (dup) o.status = STAT_DUP;
      else if (heap_n >= CAPACITY) o.status = STAT_FULL;
      else begin
        heap_key[heap_n] = r.item_key;
        heap_id[heap_n]  = r.item_id;
        heap_n++;
        heap_sift_up(heap_n - 1);
      end
    end else if (r.command >= CMD_DEL_MAX && r.command <= CMD_PEEK_MIN) begin
      if (heap_n == 0) o.status = STAT_EMPTY;
      else begin
        pos = (r.command == CMD_DEL_MAX || r.command == CMD_PEEK_MAX) ? 0 : heap_min_leaf();
        last = heap_n - 1;
        o.out_key = heap_key[pos];
        o.out_id  = heap_id[pos];
        if (r.command == CMD_DEL_MAX || r.command == CMD_DEL_MIN) begin
          heap_key[pos] = heap_key[last];
          heap_id[pos]  = heap_id[last];
          heap_n = last;
          if (r.command == CMD_DEL_MAX) heap_sift_down(0);
          else heap_sift_up(pos);
        end
      end
    end
    o.entry_count = CNT_W'(heap_n);
    return o;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsps.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", rsp_o);
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_o.status !== want.status || rsp_o.out_key !== want.out_key ||
            rsp_o.out_id !== want.out_id || rsp_o.entry_count !== want.entry_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: expected st=%0d key=%h id=%h cnt=%0d,",
                      " got st=%0d key=%h id=%h cnt=%0d"},
                     want.status, want.out_key, want.out_id, want.entry_count,
                     rsp_o.status, rsp_o.out_key, rsp_o.out_id, rsp_o.entry_count);
        end
      end
    end
  end

  // hand over one request; typed rows override the predicted result
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = heap_apply(r);
    pending_rsps.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(logic [2:0] c, logic [31:0] k, logic [31:0] d, bit typed,
                         logic [1:0] st, logic [31:0] ok, logic [31:0] oid, int cnt);
    stim_row_t row;
    row.cmd = c; row.key = k; row.id = d; row.typed = typed;
    row.rsp.status = st; row.rsp.out_key = ok; row.rsp.out_id = oid;
    row.rsp.entry_count = CNT_W'(cnt);
    stim_table.push_back(row);
  endtask

  function automatic req_t random_insert(int dup_pct);
    req_t r;
    r.command = CMD_INSERT;
    r.item_key = ($urandom_range(99) < 30) ? 32'($signed($urandom_range(8)) - 4) : $urandom;
    r.item_id = $urandom;
    if (heap_n > 0 && $urandom_range(99) < dup_pct)
      r.item_id = heap_id[$urandom_range(heap_n - 1)];
    return r;
  endfunction

  function automatic req_t random_request(int ins_pct);
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < ins_pct) return random_insert(15);
    r.item_key = $urandom;
    r.item_id  = $urandom;
    if (pick >= 97) r.command = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    else begin
      case ($urandom_range(3))
        0: r.command = CMD_DEL_MAX;
        1: r.command = CMD_DEL_MIN;
        2: r.command = CMD_PEEK_MAX;
        default: r.command = CMD_PEEK_MIN;
      endcase
    end
    return r;
  endfunction

  initial begin
    req_t r;
    rsp_t none;
    none = '0;

    add_row(CMD_PEEK_MAX, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
    add_row(CMD_PEEK_MIN, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
    add_row(CMD_DEL_MAX, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
    add_row(CMD_DEL_MIN, 0, 0, 1, STAT_EMPTY, 0, 0, 0);
    add_row(CMD_DEL_MIN, 32'hffff_ffff, 32'hffff_ffff, 1, STAT_EMPTY, 0, 0, 0);
    add_row(CMD_INSERT, 32'h7fff_ffff, 32'h0, 1, STAT_OK, 0, 0, 1);
    add_row(CMD_PEEK_MIN, 0, 0, 1, STAT_OK, 32'h7fff_ffff, 32'h0, 1);
    add_row(CMD_INSERT, 32'h8000_0000, 32'hffff_ffff, 1, STAT_OK, 0, 0, 2);
    add_row(CMD_INSERT, 32'h1234_5678, 32'h0, 1, STAT_DUP, 0, 0, 2);
    add_row(CMD_INSERT, 32'h0, 32'h5, 0, 0, 0, 0, 0);
    add_row(CMD_INSERT, 32'h0, 32'h6, 0, 0, 0, 0, 0);
    add_row(CMD_INSERT, 32'hffff_ffff, 32'h7, 0, 0, 0, 0, 0);
    add_row(CMD_INSERT, 32'h0, 32'h8, 0, 0, 0, 0, 0);
    add_row(CMD_PEEK_MAX, 0, 0, 1, STAT_OK, 32'h7fff_ffff, 32'h0, 6);
    add_row(CMD_PEEK_MIN, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_BAD_LO, 32'hffff_ffff, 32'hffff_ffff, 1, STAT_OK, 0, 0, 6);
    add_row(CMD_BAD_HI, 32'h0, 32'h5, 1, STAT_OK, 0, 0, 6);
    add_row(CMD_DEL_MIN, 0, 0, 1, STAT_OK, 32'h8000_0000, 32'hffff_ffff, 5);
    add_row(CMD_DEL_MAX, 0, 0, 1, STAT_OK, 32'h7fff_ffff, 32'h0, 4);
    add_row(CMD_DEL_MAX, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_DEL_MIN, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_DEL_MAX, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_PEEK_MIN, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_DEL_MIN, 0, 0, 1, STAT_OK, 32'h0, 32'h5, 0);
    add_row(CMD_PEEK_MAX, 0, 0, 1, STAT_EMPTY, 0, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      r.command  = stim_table[i].cmd;
      r.item_key = stim_table[i].key;
      r.item_id  = stim_table[i].id;
      send_request(r, stim_table[i].typed, stim_table[i].rsp);
    end

    // no idling, balanced mix
    idle_pct = 0;
    repeat (50) send_request(random_request(55), 0, none);

    // sender mostly idle: fill the store to capacity
    idle_pct = 84;
    while (heap_n < CAPACITY) send_request(random_insert(3), 0, none);
    repeat (3) send_request(random_insert(0), 0, none);
    repeat (2) send_request(random_insert(100), 0, none);
    repeat (30) send_request(random_request(50), 0, none);

    // hold off until every result is back
    wait_drained();

    // sender idles before a request with a 33 percent chance, draining mix
    idle_pct = 33;
    repeat (40) send_request(random_request(30), 0, none);

    idle_pct = 0;
    repeat (20) send_request(random_request(45), 0, none);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
